FILE: src/anchored_wildcard_matcher_defines.svh
// Assertion macros used by the checker file of the anchored wildcard matcher.
`ifndef ANCHORED_WILDCARD_MATCHER_DEFINES_SVH
`define ANCHORED_WILDCARD_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define AWM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("anchored_wildcard_matcher: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define AWM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("anchored_wildcard_matcher: next-cycle check failed");

`endif

FILE: src/awm_pkg.sv
// Shared types, constants and helpers of the anchored wildcard matcher.
package awm_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int CHAR_W      = 8;
	localparam int WIN_BYTES   = 8;
	localparam int PAT_W       = 64;
	localparam int LEN_W       = 4;
	localparam int COUNT_W     = 4;
	localparam int IDX_W       = 2;
	localparam int OUT_DATA_W  = 8;

	localparam logic [CHAR_W-1:0]  WILDCARD  = 8'd46;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
	localparam logic [LEN_W-1:0]   MAX_LEN   = LEN_W'(MAX_PATTERN);

	localparam logic [IDX_W-1:0] REG_PATTERN_CHARS = 2'd0;
	localparam logic [IDX_W-1:0] REG_PATTERN_LEN   = 2'd1;
	localparam logic [IDX_W-1:0] REG_ANCHOR_START  = 2'd2;
	localparam logic [IDX_W-1:0] REG_ANCHOR_END    = 2'd3;

	typedef struct packed {
		logic [PAT_W-1:0] chars;
		logic [LEN_W-1:0] len;
		logic             anchor_start;
		logic             anchor_end;
	} cfg_t;

	function automatic logic char_ok(input logic [CHAR_W-1:0] p, input logic [CHAR_W-1:0] t);
		char_ok = (p == WILDCARD) || (p == t);
	endfunction

endpackage

FILE: src/awm_cfg.sv
// Configuration register file of the anchored wildcard matcher.
module awm_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [awm_pkg::IDX_W-1:0] wr_index,
	input  logic [awm_pkg::PAT_W-1:0] wr_data,
	output awm_pkg::cfg_t             cfg
);

	awm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				awm_pkg::REG_PATTERN_CHARS: cfg_q.chars <= wr_data;
				awm_pkg::REG_PATTERN_LEN: cfg_q.len <= wr_data[awm_pkg::LEN_W-1:0];
				awm_pkg::REG_ANCHOR_START: cfg_q.anchor_start <= wr_data[0];
				awm_pkg::REG_ANCHOR_END: cfg_q.anchor_end <= wr_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/awm_match.sv
// Per-text match state and the single-pass window compare.
module awm_match (
	input  logic                       clk,
	input  logic                       arst_n,
	input  awm_pkg::cfg_t              cfg,
	input  logic                       advance,
	input  logic [awm_pkg::CHAR_W-1:0] text_byte,
	input  logic                       last_byte,
	output logic                       matched
);

	logic [awm_pkg::PAT_W-1:0]   window_q;
	logic [awm_pkg::COUNT_W-1:0] count_q;
	logic                        prefix_ok_q;
	logic                        found_q;

	logic [awm_pkg::LEN_W-1:0]   eff_len;
	logic [awm_pkg::PAT_W-1:0]   win_nx;
	logic [awm_pkg::COUNT_W-1:0] count_nx;
	logic                        prefix_nx;
	logic                        found_nx;
	logic                        win_hit;
	logic [awm_pkg::CHAR_W-1:0]  head_char;
	logic [awm_pkg::MAX_PATTERN-1:0] hit;
	logic [awm_pkg::LEN_W-1:0]   back [awm_pkg::MAX_PATTERN];

	always_comb begin
		eff_len   = (cfg.len > awm_pkg::MAX_LEN) ? awm_pkg::MAX_LEN : cfg.len;
		head_char = cfg.chars[count_q[2:0]*awm_pkg::CHAR_W +: awm_pkg::CHAR_W];
		prefix_nx = prefix_ok_q &&
			((count_q >= eff_len) || awm_pkg::char_ok(head_char, text_byte));
		win_nx    = {window_q[awm_pkg::PAT_W-awm_pkg::CHAR_W-1:0], text_byte};
		count_nx  = (count_q == awm_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;
		// Pattern char i lines up with the byte len-1-i positions back.
		for (int i = 0; i < awm_pkg::MAX_PATTERN; i++) begin
			back[i] = eff_len - awm_pkg::LEN_W'(1) - awm_pkg::LEN_W'(i);
			hit[i]  = (awm_pkg::LEN_W'(i) >= eff_len) || awm_pkg::char_ok(
				cfg.chars[i*awm_pkg::CHAR_W +: awm_pkg::CHAR_W],
				win_nx[back[i][2:0]*awm_pkg::CHAR_W +: awm_pkg::CHAR_W]);
		end
		win_hit  = (count_nx >= eff_len) && (&hit);
		found_nx = found_q || win_hit;
		case ({cfg.anchor_start, cfg.anchor_end})
			2'b11: matched = prefix_nx && (count_nx == eff_len);
			2'b10: matched = prefix_nx && (count_nx >= eff_len);
			2'b01: matched = win_hit;
			default: matched = found_nx;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			count_q     <= '0;
			prefix_ok_q <= 1'b1;
			found_q     <= 1'b0;
		end else if (advance) begin
			if (last_byte) begin
				window_q    <= '0;
				count_q     <= '0;
				prefix_ok_q <= 1'b1;
				found_q     <= 1'b0;
			end else begin
				window_q    <= win_nx;
				count_q     <= count_nx;
				prefix_ok_q <= prefix_nx;
				found_q     <= found_nx;
			end
		end
	end

endmodule

FILE: src/anchored_wildcard_matcher.sv
// Top level of the anchored wildcard matcher: stream ports, input and result registers.
// The text streams in one byte per transfer on the s_axis side, with tlast on its final
// byte. Each byte is compared against a pattern of up to 8 characters ('.' matches any
// byte) held in configuration registers, in one of four modes chosen by the anchor bits:
// anywhere, at the start, at the end, or the whole text. Only the final byte produces a
// result: one m_axis transfer whose tdata bit 0 is the match bit. A new byte is taken
// every cycle unless the input side stalls; the last byte of a text passes the input
// register, then the parallel compare of the 8-byte window, then the result register,
// from which the result of the text is offered on m_axis. The input side stalls only
// when a result waits in the result register and the downstream side is not ready.
// Configuration writes are always accepted and apply to bytes compared after the write;
// write them only while no text byte or result is in flight.
module anchored_wildcard_matcher (
	input  logic                           clk,
	input  logic                           arst_n,
	// Text input
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [awm_pkg::CHAR_W-1:0]     s_axis_tdata,  // [7:0] text_byte
	input  logic                           s_axis_tlast,  // last_byte
	// Match result
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [awm_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [0] matched, [7:1] zero
	// Register write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [awm_pkg::IDX_W-1:0]      cfg_index,
	input  logic [awm_pkg::PAT_W-1:0]      cfg_data
);

	awm_pkg::cfg_t cfg;

	// Input stage
	logic                       valid_s1;
	logic [awm_pkg::CHAR_W-1:0] byte_s1;
	logic                       last_s1;

	// Result register
	logic out_valid_q;
	logic matched_q;

	logic out_free;
	logic advance;
	logic matched;

	// Register writes never stall.
	assign cfg_ready = 1'b1;

	awm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// A non-last byte always advances; the last one needs room in the result register.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Payload needs no reset: load on every accepted transfer.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	awm_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.advance   (advance),
		.text_byte (byte_s1),
		.last_byte (last_s1),
		.matched   (matched)
	);

	// Load the result on the final byte; drop it once the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			matched_q <= matched;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(awm_pkg::OUT_DATA_W-1){1'b0}}, matched_q};

endmodule

FILE: src/awm_checker.sv
// Port-level checks of the anchored wildcard matcher, bound to the top level.
`include "anchored_wildcard_matcher_defines.svh"

module awm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [awm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                           cfg_valid,
	input logic                           cfg_ready
);

	// Only the match bit may be set in a result.
	`AWM_ASSERT_NOW(a_result_pad_zero, m_axis_tvalid, m_axis_tdata[awm_pkg::OUT_DATA_W-1:1] == '0)

	// The input side stalls only behind a result the downstream side refuses.
	`AWM_ASSERT_NOW(a_stall_only_on_backpressure, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

	// Register writes are never held off.
	`AWM_ASSERT_NOW(a_cfg_always_ready, cfg_valid, cfg_ready)

	// A refused result stays offered and unchanged.
	`AWM_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind anchored_wildcard_matcher awm_checker u_awm_checker (.*);
